// ===== rtl/core/thsc_pkg.sv =====
// Shared types and constants for the touch hold and slide classifier.
// Used by every module of the block; depends on nothing else.
package thsc_pkg;

    // Fixed width of one touch bitmap word
    localparam int TOUCH_W = 8;

    // Sum of touched electrode indices and number of touched electrodes
    localparam int SUM_W   = $clog2(TOUCH_W * (TOUCH_W - 1) / 2 + 1);
    localparam int CNT_W   = $clog2(TOUCH_W + 1);
    localparam int PROD_W  = SUM_W + CNT_W;

    // Parameter defaults
    localparam int ELECTRODES_DEF     = 8;
    localparam int HOLD_SAMPLES_DEF   = 100;
    localparam int GESTURE_WINDOW_DEF = 10;

    typedef enum logic [1:0] {
        GEST_NONE = 2'd0,
        GEST_RISE = 2'd1,
        GEST_FALL = 2'd2,
        GEST_TAP  = 2'd3
    } gesture_t;

    // One processing step handed to the state units
    typedef struct packed {
        logic               en;
        logic [TOUCH_W-1:0] bits;
    } step_t;

endpackage

// ===== rtl/core/touch_hold_and_slide_classifier.sv =====
// An accepted word waits in the input register, then moves to the result register that
// drives out_valid; it stays in the input register while out_stall holds a waiting result.
// Throughput: one word per cycle unless out_stall holds a waiting result; each word
// passes once through the short logic between the input register and the result register.
// Reset: asynchronous, active low; empties both pipeline registers, clears the run counters
// and gesture window, loads centroid zero into the centroid window, sets hold flag and phase.
// Top level; depends on thsc_pkg, thsc_hold and thsc_slide.
module touch_hold_and_slide_classifier
    import thsc_pkg::*;
#(
    parameter int ELECTRODES     = ELECTRODES_DEF,
    parameter int HOLD_SAMPLES   = HOLD_SAMPLES_DEF,
    parameter int GESTURE_WINDOW = GESTURE_WINDOW_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [TOUCH_W-1:0] touch_bits,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hold,
    output logic [1:0]         gesture
);

    logic               in_vld_reg;
    logic [TOUCH_W-1:0] in_bits_reg;
    logic               out_vld_reg;
    logic               out_hold_reg;
    gesture_t           out_gesture_reg;
    logic               advance;
    logic               accept;
    logic               hold_now;
    gesture_t           slide_gesture;
    step_t              hold_step;
    step_t              slide_step;

    // Move a word to the result register when that register is free or draining
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign hold_step.en    = advance;
    assign hold_step.bits  = in_bits_reg;
    assign slide_step.en   = advance && !hold_now;
    assign slide_step.bits = in_bits_reg;

    thsc_hold #(
        .ELECTRODES   (ELECTRODES),
        .HOLD_SAMPLES (HOLD_SAMPLES)
    ) u_hold (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (hold_step),
        .hold_now (hold_now)
    );

    thsc_slide #(
        .ELECTRODES     (ELECTRODES),
        .GESTURE_WINDOW (GESTURE_WINDOW)
    ) u_slide (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (slide_step),
        .gesture (slide_gesture)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (accept)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_bits_reg <= touch_bits;
    end

    // Result register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_hold_reg    <= hold_now;
            out_gesture_reg <= hold_now ? GEST_NONE : slide_gesture;
        end
    end

    assign out_valid = out_vld_reg;
    assign hold      = out_hold_reg;
    assign gesture   = out_gesture_reg;

endmodule

// ===== rtl/core/thsc_hold.sv =====
// Hold detector: per-electrode saturating run counters, evaluated every other word.
// Depends on thsc_pkg.
module thsc_hold
    import thsc_pkg::*;
#(
    parameter int ELECTRODES   = ELECTRODES_DEF,
    parameter int HOLD_SAMPLES = HOLD_SAMPLES_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  step_t step,
    output logic  hold_now
);

    localparam int RUN_W = $clog2(HOLD_SAMPLES + 1);
    localparam int PAD_W = (ELECTRODES > TOUCH_W) ? ELECTRODES : TOUCH_W;

    logic [RUN_W-1:0] run_reg  [ELECTRODES];
    logic [RUN_W-1:0] run_next [ELECTRODES];
    logic             phase_reg;
    logic             flag_reg;
    logic             any_held;
    logic [PAD_W-1:0] bits_ext;

    // Electrodes past the bitmap width read as untouched
    assign bits_ext = PAD_W'(step.bits);

    // Advance each run counter, clear on release, saturate at the window
    always_comb
    begin
        any_held = 1'b0;
        for (int e = 0; e < ELECTRODES; e++)
        begin
            if (bits_ext[e])
            begin
                if (run_reg[e] < RUN_W'(HOLD_SAMPLES))
                    run_next[e] = run_reg[e] + RUN_W'(1);
                else
                    run_next[e] = run_reg[e];
            end
            else
            begin
                run_next[e] = '0;
            end
            if (run_next[e] >= RUN_W'(HOLD_SAMPLES))
                any_held = 1'b1;
        end
    end

    // Off-phase words keep the last evaluated flag
    assign hold_now = phase_reg ? any_held : flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b1;
            flag_reg  <= 1'b1;
            for (int e = 0; e < ELECTRODES; e++)
                run_reg[e] <= '0;
        end
        else if (step.en)
        begin
            phase_reg <= ~phase_reg;
            if (phase_reg)
            begin
                flag_reg <= any_held;
                for (int e = 0; e < ELECTRODES; e++)
                    run_reg[e] <= run_next[e];
            end
        end
    end

endmodule

// ===== rtl/core/thsc_slide.sv =====
// Slide classifier: centroid window, direction compare and running gesture vote.
// Depends on thsc_pkg.
module thsc_slide
    import thsc_pkg::*;
#(
    parameter int ELECTRODES     = ELECTRODES_DEF,
    parameter int GESTURE_WINDOW = GESTURE_WINDOW_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  step_t    step,
    output gesture_t gesture
);

    localparam int LANES  = (ELECTRODES < TOUCH_W) ? ELECTRODES : TOUCH_W;
    localparam int WIN    = GESTURE_WINDOW;
    localparam int VOTE_W = $clog2(WIN + 1);
    localparam int EMP_W  = $clog2(WIN + 1);

    logic [SUM_W-1:0]  sums_reg  [WIN];
    logic [CNT_W-1:0]  cnts_reg  [WIN];
    gesture_t          hist_reg  [WIN-1];
    logic [EMP_W-1:0]  empty_reg;
    logic [VOTE_W-1:0] votes0_reg;
    logic [VOTE_W-1:0] votes1_reg;
    logic [VOTE_W-1:0] votes2_reg;

    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  cnt;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    logic              dir_ok;
    gesture_t          g_new;
    logic [VOTE_W-1:0] v0;
    logic [VOTE_W-1:0] v1;
    logic [VOTE_W-1:0] v2;
    logic [VOTE_W-1:0] best;
    gesture_t          winner;
    logic [EMP_W-1:0]  empty_next;
    logic [VOTE_W-1:0] votes0_next;
    logic [VOTE_W-1:0] votes1_next;
    logic [VOTE_W-1:0] votes2_next;

    // Index sum and touch count of the new word
    always_comb
    begin
        sum = '0;
        cnt = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (step.bits[i])
            begin
                sum = sum + SUM_W'(i);
                cnt = cnt + CNT_W'(1);
            end
        end
    end

    // Compare against the oldest centroid by cross-multiplication
    assign lhs    = PROD_W'(sums_reg[0]) * PROD_W'(cnt);
    assign rhs    = PROD_W'(sum) * PROD_W'(cnts_reg[0]);
    assign dir_ok = (cnt != '0) && (empty_reg == '0);

    always_comb
    begin
        g_new = GEST_NONE;
        if (dir_ok && (lhs < rhs))
            g_new = GEST_RISE;
        else if (dir_ok && (lhs > rhs))
            g_new = GEST_FALL;
        else if (step.bits[0])
            g_new = GEST_TAP;
    end

    // Vote over the new gesture plus the stored ones
    assign v0 = votes0_reg + VOTE_W'(g_new == GEST_NONE);
    assign v1 = votes1_reg + VOTE_W'(g_new == GEST_RISE);
    assign v2 = votes2_reg + VOTE_W'(g_new == GEST_FALL);

    always_comb
    begin
        winner = GEST_NONE;
        best   = v0;
        if (best < v1)
        begin
            winner = GEST_RISE;
            best   = v1;
        end
        if (best < v2)
            winner = GEST_FALL;
    end

    assign gesture = (g_new == GEST_TAP) ? GEST_TAP : winner;

    // Running counts: drop the oldest stored entry, add the new one
    assign empty_next  = empty_reg - EMP_W'(cnts_reg[0] == '0) + EMP_W'(cnt == '0);
    assign votes0_next = v0 - VOTE_W'(hist_reg[0] == GEST_NONE);
    assign votes1_next = v1 - VOTE_W'(hist_reg[0] == GEST_RISE);
    assign votes2_next = v2 - VOTE_W'(hist_reg[0] == GEST_FALL);

    // Shift the centroid and gesture windows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                sums_reg[i] <= '0;
                cnts_reg[i] <= CNT_W'(1);
            end
            for (int i = 0; i < WIN - 1; i++)
                hist_reg[i] <= GEST_NONE;
            empty_reg  <= '0;
            votes0_reg <= VOTE_W'(WIN - 1);
            votes1_reg <= '0;
            votes2_reg <= '0;
        end
        else if (step.en)
        begin
            for (int i = 0; i < WIN - 1; i++)
            begin
                sums_reg[i] <= sums_reg[i+1];
                cnts_reg[i] <= cnts_reg[i+1];
            end
            sums_reg[WIN-1] <= sum;
            cnts_reg[WIN-1] <= cnt;
            for (int i = 0; i < WIN - 2; i++)
                hist_reg[i] <= hist_reg[i+1];
            hist_reg[WIN-2] <= g_new;
            empty_reg  <= empty_next;
            votes0_reg <= votes0_next;
            votes1_reg <= votes1_next;
            votes2_reg <= votes2_next;
        end
    end

endmodule

// ===== rtl/core/thsc_checker.sv =====
// Port-level checks for the touch hold and slide classifier, bound to the top level.
// Depends on thsc_pkg and touch_hold_and_slide_classifier.
module thsc_checker
    import thsc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       hold,
    input logic [1:0] gesture
);

    // A held result never carries a gesture
    a_hold_no_gesture: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hold |-> gesture == GEST_NONE)
        else $error("gesture reported while hold is set");

    // The input side stalls only when a result is waiting and stalled
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // A stalled result stays valid and unchanged
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hold) && $stable(gesture))
        else $error("stalled result changed");

    // A stalled new word never causes the waiting result to be dropped
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> out_valid)
        else $error("result dropped while input stalled");

endmodule

bind touch_hold_and_slide_classifier thsc_checker u_thsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hold      (hold),
    .gesture   (gesture)
);
